@@ rtl/efrr_pkg.sv @@
// Shared types, codes and constants of the escaped frame ring receiver.
`timescale 1ns / 1ps

package efrr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int RING_DEPTH_DEF = 256;
  localparam int MAX_FRAME_DEF  = 64;

  // Line coding constants.
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam int         MIN_FRAME = 6;

  // Input item modes.
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_IDLE  = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OTHER = 3'd1;
  localparam logic [2:0] ST_NONE  = 3'd2;
  localparam logic [2:0] ST_SHORT = 3'd3;
  localparam logic [2:0] ST_OVER  = 3'd4;

  // Configuration register indexes.
  localparam int         CFG_IDX_W      = 1;
  localparam logic [0:0] CFG_OWN_ADDR   = 1'b0;
  localparam logic [0:0] CFG_SLAVE_MODE = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last;
    logic [2:0] status;
    logic       frame_pending;
  } out_item_t;

endpackage

@@ rtl/efrr_ram.sv @@
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module efrr_ram #(
  parameter int DEPTH = efrr_pkg::RING_DEPTH_DEF,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write and one read per cycle; read data is registered and appears in the cycle after its address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/efrr_out_slot.sv @@
// Output register that holds one result until the consumer takes it.
`timescale 1ns / 1ps

module efrr_out_slot (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  efrr_pkg::out_item_t load_item,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output efrr_pkg::out_item_t out_item
);

  logic                valid_r;
  efrr_pkg::out_item_t item_r;

  // The slot can take a new result when empty or when its content leaves now.
  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ rtl/escaped_frame_ring_receiver.sv @@
// Frame ring receiver: byte stuffing into a ring memory and frame fetch with unstuffing.
// Items: a line byte or line idle item is handled one at a time, and an escaped byte
// writes two ring entries through the single write port.
// A fetch walks the two delimiter scans, unstuffs the ring entries and emits the results,
// with one ring read per cycle; no new item is taken until the last result is loaded.
// Reset: a clearing pass writes every ring entry with in_ready low;
// configuration writes are taken throughout.
`timescale 1ns / 1ps

module escaped_frame_ring_receiver #(
  parameter int RING_DEPTH = efrr_pkg::RING_DEPTH_DEF,
  parameter int MAX_FRAME  = efrr_pkg::MAX_FRAME_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  efrr_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output efrr_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [efrr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int NW  = $clog2(MAX_FRAME);
  localparam int NCW = $clog2(MAX_FRAME + 1);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_WR2     = 4'd2;
  localparam logic [3:0] S_EMIT    = 4'd3;
  localparam logic [3:0] S_A_PRIME = 4'd4;
  localparam logic [3:0] S_A_RUN   = 4'd5;
  localparam logic [3:0] S_B_PRIME = 4'd6;
  localparam logic [3:0] S_B_RUN   = 4'd7;
  localparam logic [3:0] S_U_PRIME = 4'd8;
  localparam logic [3:0] S_U_RUN   = 4'd9;
  localparam logic [3:0] S_F_RD    = 4'd10;
  localparam logic [3:0] S_F_OUT   = 4'd11;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    ring_prev = (p == '0) ? AW'(RING_DEPTH - 1) : p - 1'b1;
  endfunction

  logic [3:0]     state_r, state_nxt;
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [AW-1:0]  rp_r, rp_nxt;
  logic [AW-1:0]  scan_p_r, scan_p_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt;
  logic [7:0]     first_byte_r, first_byte_nxt;
  logic           frame_ready_r, frame_ready_nxt;
  logic [7:0]     own_address_r;
  logic           slave_mode_r;
  logic [2:0]     res_status_r, res_status_nxt;
  logic [7:0]     wr2_byte_r, wr2_byte_nxt;
  logic [NCW-1:0] n_r, n_nxt;
  logic [NCW-1:0] idx_r, idx_nxt;
  logic           esc_r, esc_nxt;
  logic [7:0]     pkg0_r, pkg0_nxt;

  logic           ring_we;
  logic [AW-1:0]  ring_waddr;
  logic [7:0]     ring_wdata;
  logic [AW-1:0]  ring_raddr;
  logic [7:0]     ring_rdata;
  logic           fb_we;
  logic [7:0]     fb_wdata;
  logic [NW-1:0]  fb_raddr;
  logic [7:0]     fb_rdata;

  logic                slot_load;
  logic                slot_free;
  efrr_pkg::out_item_t slot_item;

  logic [7:0]     fb_eff;
  logic [AW-1:0]  wp_inc;
  logic [AW-1:0]  rp_inc;
  logic [AW-1:0]  p_next;
  logic [AW-1:0]  p_prev;
  logic [7:0]     u_byte;
  logic [NCW-1:0] idx_inc;
  logic           f_last;
  logic           rx_needs_esc;

  // Ring memory holds the stuffed line bytes; frame buffer holds one unstuffed frame.
  efrr_ram #(.DEPTH(RING_DEPTH), .WIDTH(8)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  efrr_ram #(.DEPTH(MAX_FRAME), .WIDTH(8)) u_fbuf (
    .clk   (clk),
    .we    (fb_we),
    .waddr (n_r[NW-1:0]),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  efrr_out_slot u_slot (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (slot_load),
    .load_item (slot_item),
    .free      (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Helper values for the sequencer.
  assign fb_eff       = (first_byte_r == 8'h00) ? in_item.rx_byte : first_byte_r;
  assign wp_inc       = ring_next(wp_r);
  assign rp_inc       = ring_next(rp_r);
  assign p_next       = ring_next(scan_p_r);
  assign p_prev       = ring_prev(scan_p_r);
  assign u_byte       = esc_r ? (ring_rdata ^ efrr_pkg::ESC_XOR) : ring_rdata;
  assign idx_inc      = idx_r + 1'b1;
  assign f_last       = (idx_r == n_r - NCW'(3));
  assign rx_needs_esc = (in_item.rx_byte == efrr_pkg::FLAG_BYTE) ||
                        (in_item.rx_byte == efrr_pkg::ESC_BYTE);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer: ring writes, the two delimiter scans, unstuffing and emission.
  always_comb begin
    state_nxt       = state_r;
    wp_nxt          = wp_r;
    rp_nxt          = rp_r;
    scan_p_nxt      = scan_p_r;
    cnt_nxt         = cnt_r;
    first_byte_nxt  = first_byte_r;
    frame_ready_nxt = frame_ready_r;
    res_status_nxt  = res_status_r;
    wr2_byte_nxt    = wr2_byte_r;
    n_nxt           = n_r;
    idx_nxt         = idx_r;
    esc_nxt         = esc_r;
    pkg0_nxt        = pkg0_r;
    ring_we         = 1'b0;
    ring_waddr      = wp_inc;
    ring_wdata      = 8'h00;
    ring_raddr      = rp_r;
    fb_we           = 1'b0;
    fb_wdata        = u_byte;
    fb_raddr        = idx_r[NW-1:0];
    slot_load       = 1'b0;
    slot_item       = '0;

    case (state_r)
      S_CLR: begin
        ring_we    = 1'b1;
        ring_waddr = cnt_r;
        ring_wdata = (cnt_r == '0) ? efrr_pkg::FLAG_BYTE : 8'h00;
        if (cnt_r == AW'(RING_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          case (in_item.mode)
            efrr_pkg::MODE_BYTE: begin
              first_byte_nxt = fb_eff;
              state_nxt      = S_EMIT;
              if (slave_mode_r && (fb_eff != own_address_r)) begin
                res_status_nxt = efrr_pkg::ST_OTHER;
              end else begin
                res_status_nxt = efrr_pkg::ST_OK;
                ring_we        = 1'b1;
                wp_nxt         = wp_inc;
                if (rx_needs_esc) begin
                  ring_wdata   = efrr_pkg::ESC_BYTE;
                  wr2_byte_nxt = in_item.rx_byte ^ efrr_pkg::ESC_XOR;
                  state_nxt    = S_WR2;
                end else begin
                  ring_wdata = in_item.rx_byte;
                end
              end
            end
            efrr_pkg::MODE_IDLE: begin
              first_byte_nxt = 8'h00;
              state_nxt      = S_EMIT;
              if (slave_mode_r && (first_byte_r != own_address_r)) begin
                res_status_nxt = efrr_pkg::ST_OTHER;
              end else begin
                res_status_nxt  = efrr_pkg::ST_OK;
                ring_we         = 1'b1;
                ring_wdata      = efrr_pkg::FLAG_BYTE;
                wp_nxt          = wp_inc;
                frame_ready_nxt = 1'b1;
              end
            end
            efrr_pkg::MODE_FETCH: begin
              state_nxt = S_A_PRIME;
            end
            default: begin
              res_status_nxt = efrr_pkg::ST_OK;
              state_nxt      = S_EMIT;
            end
          endcase
        end
      end

      // Second entry of an escaped byte.
      S_WR2: begin
        ring_we    = 1'b1;
        ring_wdata = wr2_byte_r;
        wp_nxt     = wp_inc;
        state_nxt  = S_EMIT;
      end

      // Single result without data.
      S_EMIT: begin
        if (slot_free) begin
          slot_load               = 1'b1;
          slot_item.last          = 1'b1;
          slot_item.status        = res_status_r;
          slot_item.frame_pending = frame_ready_r;
          state_nxt               = S_IDLE;
        end
      end

      // Forward scan from the read position to the next delimiter.
      S_A_PRIME: begin
        ring_raddr = rp_r;
        scan_p_nxt = rp_r;
        cnt_nxt    = '0;
        state_nxt  = S_A_RUN;
      end

      S_A_RUN: begin
        if (ring_rdata == efrr_pkg::FLAG_BYTE) begin
          rp_nxt    = scan_p_r;
          state_nxt = S_B_PRIME;
        end else if (cnt_r == AW'(RING_DEPTH - 1)) begin
          frame_ready_nxt = 1'b0;
          res_status_nxt  = efrr_pkg::ST_NONE;
          state_nxt       = S_EMIT;
        end else begin
          ring_raddr = p_next;
          scan_p_nxt = p_next;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end

      // Backward scan from the write position to the last delimiter.
      S_B_PRIME: begin
        ring_raddr = wp_r;
        scan_p_nxt = wp_r;
        cnt_nxt    = '0;
        state_nxt  = S_B_RUN;
      end

      S_B_RUN: begin
        if (ring_rdata == efrr_pkg::FLAG_BYTE) begin
          if (rp_r == scan_p_r) begin
            frame_ready_nxt = 1'b0;
            res_status_nxt  = efrr_pkg::ST_NONE;
            state_nxt       = S_EMIT;
          end else begin
            state_nxt = S_U_PRIME;
          end
        end else if (cnt_r == AW'(RING_DEPTH - 1)) begin
          frame_ready_nxt = 1'b0;
          res_status_nxt  = efrr_pkg::ST_NONE;
          state_nxt       = S_EMIT;
        end else begin
          ring_raddr = p_prev;
          scan_p_nxt = p_prev;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end

      // Unstuff one ring entry per cycle into the frame buffer.
      S_U_PRIME: begin
        ring_raddr = rp_inc;
        scan_p_nxt = rp_inc;
        n_nxt      = '0;
        esc_nxt    = 1'b0;
        state_nxt  = S_U_RUN;
      end

      S_U_RUN: begin
        rp_nxt     = scan_p_r;
        ring_raddr = p_next;
        scan_p_nxt = p_next;
        if (!esc_r && (ring_rdata == efrr_pkg::FLAG_BYTE)) begin
          if (n_r < NCW'(efrr_pkg::MIN_FRAME)) begin
            res_status_nxt = efrr_pkg::ST_SHORT;
            state_nxt      = S_EMIT;
          end else if (slave_mode_r && (pkg0_r != own_address_r)) begin
            res_status_nxt = efrr_pkg::ST_OTHER;
            state_nxt      = S_EMIT;
          end else begin
            idx_nxt   = NCW'(1);
            state_nxt = S_F_RD;
          end
        end else if (!esc_r && (ring_rdata == efrr_pkg::ESC_BYTE)) begin
          esc_nxt = 1'b1;
        end else begin
          fb_we   = 1'b1;
          esc_nxt = 1'b0;
          n_nxt   = n_r + 1'b1;
          if (n_r == '0) begin
            pkg0_nxt = u_byte;
          end
          if (n_r == NCW'(MAX_FRAME - 1)) begin
            res_status_nxt = efrr_pkg::ST_OVER;
            state_nxt      = S_EMIT;
          end
        end
      end

      // Emit the function and data bytes, one result per cycle when the slot allows.
      S_F_RD: begin
        fb_raddr  = idx_r[NW-1:0];
        state_nxt = S_F_OUT;
      end

      S_F_OUT: begin
        fb_raddr = idx_r[NW-1:0];
        if (slot_free) begin
          slot_load               = 1'b1;
          slot_item.data_valid    = 1'b1;
          slot_item.data_byte     = fb_rdata;
          slot_item.last          = f_last;
          slot_item.status        = efrr_pkg::ST_OK;
          slot_item.frame_pending = frame_ready_r;
          if (f_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt  = idx_inc;
            fb_raddr = idx_inc[NW-1:0];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      wp_r          <= '0;
      rp_r          <= '0;
      cnt_r         <= '0;
      first_byte_r  <= 8'h00;
      frame_ready_r <= 1'b0;
      esc_r         <= 1'b0;
      n_r           <= '0;
      idx_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      wp_r          <= wp_nxt;
      rp_r          <= rp_nxt;
      cnt_r         <= cnt_nxt;
      first_byte_r  <= first_byte_nxt;
      frame_ready_r <= frame_ready_nxt;
      esc_r         <= esc_nxt;
      n_r           <= n_nxt;
      idx_r         <= idx_nxt;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    scan_p_r     <= scan_p_nxt;
    res_status_r <= res_status_nxt;
    wr2_byte_r   <= wr2_byte_nxt;
    pkg0_r       <= pkg0_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= 8'h01;
      slave_mode_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        efrr_pkg::CFG_OWN_ADDR:   own_address_r <= cfg_data;
        efrr_pkg::CFG_SLAVE_MODE: slave_mode_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The write position moves only for an accepted item or the second escaped entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WR2 && !(in_valid && in_ready)) |=> $stable(wp_r))
    else $error("write position moved without a ring write");

  // The read position holds while the block waits for a transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !(in_valid && in_ready)) |=> $stable(rp_r))
    else $error("read position moved while idle");

  // Emitted frame bytes stay between the address byte and the check bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_F_OUT) |-> (idx_r != '0 && (idx_r + NCW'(3)) <= n_r && !esc_r))
    else $error("frame byte index out of range");

  // Data results always carry an ok status.
  assert property (@(posedge clk) disable iff (!rst_n)
    (slot_load && slot_item.data_valid) |-> (slot_item.status == efrr_pkg::ST_OK))
    else $error("data result with failure status");

endmodule

@@ tb/tb_escaped_frame_ring_receiver.sv @@
// Self-checking testbench for the escaped frame ring receiver: frame traffic, fetches and checks.
`timescale 1ns / 1ps

module tb_escaped_frame_ring_receiver;
  import efrr_pkg::*;

  localparam int RING_SIZE = RING_DEPTH_DEF;
  localparam int FRAME_LIMIT = MAX_FRAME_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES = 100;
  localparam int IDLE_PERCENT = 18;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = 8'h00;

  // Line items waiting to be driven and results predicted but not yet seen.
  in_item_t line_items[$];
  out_item_t predicted_out[$];
  int n_queued = 0;
  int n_accepted = 0;
  int error_count = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  // Shadow copy of the receiver state and its registers.
  logic [7:0] ring_copy[RING_SIZE];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  logic [7:0] frame_addr;
  bit frame_done;
  logic [7:0] station_addr;
  bit filter_on;

  escaped_frame_ring_receiver DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned ring_inc(int unsigned p);
    return (p + 1 >= RING_SIZE) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ring_dec(int unsigned p);
    return (p == 0) ? RING_SIZE - 1 : p - 1;
  endfunction

  task automatic store_entry(logic [7:0] v);
    wr_ptr = ring_inc(wr_ptr);
    ring_copy[wr_ptr] = v;
  endtask

  task automatic expect_result(bit valid, logic [7:0] b, bit is_last, logic [2:0] st);
    out_item_t r;
    r.data_valid = valid;
    r.data_byte = b;
    r.last = is_last;
    r.status = st;
    r.frame_pending = frame_done;
    predicted_out.push_back(r);
  endtask

  function automatic bit addr_blocked();
    return filter_on && (frame_addr != station_addr);
  endfunction

  // Fetch: skip to a delimiter, find the newest delimiter, unstuff one frame.
  task automatic predict_fetch_frame();
    logic [7:0] frame_buf[FRAME_LIMIT];
    int unsigned n;
    int unsigned end_ptr;
    int unsigned k;
    bit walking;
    logic [7:0] c;
    logic [2:0] st;
    n = 0;
    end_ptr = wr_ptr;
    st = ST_OK;
    k = 0;
    while (k < RING_SIZE && ring_copy[rd_ptr] != FLAG_BYTE) begin
      rd_ptr = ring_inc(rd_ptr);
      k++;
    end
    k = 0;
    while (k < RING_SIZE && ring_copy[end_ptr] != FLAG_BYTE) begin
      end_ptr = ring_dec(end_ptr);
      k++;
    end
    if (ring_copy[rd_ptr] != FLAG_BYTE || ring_copy[end_ptr] != FLAG_BYTE ||
        rd_ptr == end_ptr) begin
      frame_done = 1'b0;
      expect_result(1'b0, 8'h00, 1'b1, ST_NONE);
    end else begin
      walking = 1'b1;
      while (walking) begin
        rd_ptr = ring_inc(rd_ptr);
        c = ring_copy[rd_ptr];
        if (c == FLAG_BYTE) begin
          walking = 1'b0;
        end else begin
          // An escape always takes the following entry, whatever it holds.
          if (c == ESC_BYTE) begin
            rd_ptr = ring_inc(rd_ptr);
            c = ring_copy[rd_ptr] ^ ESC_XOR;
          end
          frame_buf[n] = c;
          n++;
          if (n >= FRAME_LIMIT) begin
            st = ST_OVER;
            walking = 1'b0;
          end
        end
      end
      if (st == ST_OK && n < MIN_FRAME) st = ST_SHORT;
      if (st == ST_OK && filter_on && frame_buf[0] != station_addr) st = ST_OTHER;
      if (st != ST_OK) begin
        expect_result(1'b0, 8'h00, 1'b1, st);
      end else begin
        // The address byte and the two check bytes are not delivered.
        for (k = 1; k + 2 < n; k++) begin
          expect_result(1'b1, frame_buf[k], k + 3 == n, ST_OK);
        end
      end
    end
  endtask

  task automatic predict_ring_item(in_item_t it);
    case (it.mode)
      MODE_BYTE: begin
        if (frame_addr == 8'h00) frame_addr = it.rx_byte;
        if (addr_blocked()) begin
          expect_result(1'b0, 8'h00, 1'b1, ST_OTHER);
        end else begin
          if (it.rx_byte == FLAG_BYTE || it.rx_byte == ESC_BYTE) begin
            store_entry(ESC_BYTE);
            store_entry(it.rx_byte ^ ESC_XOR);
          end else begin
            store_entry(it.rx_byte);
          end
          expect_result(1'b0, 8'h00, 1'b1, ST_OK);
        end
      end
      MODE_IDLE: begin
        if (addr_blocked()) begin
          frame_addr = 8'h00;
          expect_result(1'b0, 8'h00, 1'b1, ST_OTHER);
        end else begin
          store_entry(FLAG_BYTE);
          frame_done = 1'b1;
          frame_addr = 8'h00;
          expect_result(1'b0, 8'h00, 1'b1, ST_OK);
        end
      end
      MODE_FETCH: begin
        predict_fetch_frame();
      end
      default: begin
        expect_result(1'b0, 8'h00, 1'b1, ST_OK);
      end
    endcase
  endtask

  // Input driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_ring_item(in_item);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (line_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_valid <= 1'b1;
          in_item <= line_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transaction with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    if (rst_n && out_valid && out_ready) begin
      if (predicted_out.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: valid=%0b byte=%02h last=%0b status=%0d pending=%0b",
                   out_item.data_valid, out_item.data_byte, out_item.last,
                   out_item.status, out_item.frame_pending);
        end
      end else begin
        want = predicted_out.pop_front();
        if (out_item.data_valid !== want.data_valid || out_item.data_byte !== want.data_byte ||
            out_item.last !== want.last || out_item.status !== want.status ||
            out_item.frame_pending !== want.frame_pending) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected valid=%0b byte=%02h last=%0b status=%0d pending=%0b",
                     want.data_valid, want.data_byte, want.last, want.status,
                     want.frame_pending);
            $display("          actual   valid=%0b byte=%02h last=%0b status=%0d pending=%0b",
                     out_item.data_valid, out_item.data_byte, out_item.last,
                     out_item.status, out_item.frame_pending);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_item(logic [1:0] mode, logic [7:0] b);
    in_item_t it;
    it.mode = mode;
    it.rx_byte = b;
    line_items.push_back(it);
    n_queued++;
  endtask

  // Line byte with the delimiter and escape values well represented.
  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 7))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame on the line: address, further bytes, then line idle.
  task automatic queue_frame(logic [7:0] addr, int len);
    queue_item(MODE_BYTE, addr);
    repeat (len - 1) queue_item(MODE_BYTE, line_byte());
    queue_item(MODE_IDLE, 8'h00);
  endtask

  // Mostly well-formed frames and fetches, with short, misaddressed and noise traffic.
  task automatic queue_traffic(int budget);
    int first;
    int pick;
    logic [7:0] addr;
    first = n_queued;
    while (n_queued - first < budget) begin
      pick = $urandom_range(0, 99);
      addr = filter_on ? station_addr : 8'($urandom_range(1, 255));
      if (pick < 60) begin
        queue_frame(addr, $urandom_range(6, 14));
        if ($urandom_range(0, 9) < 7) queue_item(MODE_FETCH, 8'h00);
      end else if (pick < 72) begin
        queue_frame(addr, $urandom_range(1, 5));
        queue_item(MODE_FETCH, 8'h00);
      end else if (pick < 80) begin
        queue_frame(8'($urandom_range(0, 255)), $urandom_range(6, 10));
        queue_item(MODE_FETCH, 8'h00);
      end else if (pick < 88) begin
        queue_item(MODE_FETCH, 8'h00);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Wait until every queued transaction is taken and every result has come.
  task automatic wait_drained(int extra);
    while (n_accepted != n_queued || predicted_out.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_OWN_ADDR) station_addr = val;
    else filter_on = val[0];
    cfg_valid <= 1'b0;
  endtask

  initial begin
    foreach (ring_copy[i]) ring_copy[i] = 8'h00;
    ring_copy[0] = FLAG_BYTE;
    wr_ptr = 0;
    rd_ptr = 0;
    frame_addr = 8'h00;
    frame_done = 1'b0;
    station_addr = 8'h01;
    filter_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset settings: empty ring, foreign station,
    // zero leading byte, a stuffed frame, a repeated fetch, a short frame.
    queue_item(MODE_FETCH, 8'h00);
    queue_item(MODE_BYTE, 8'h05);
    queue_item(MODE_IDLE, 8'h00);
    queue_item(MODE_BYTE, 8'h00);
    queue_item(MODE_IDLE, 8'h00);
    queue_item(MODE_BYTE, 8'h01);
    queue_item(MODE_BYTE, 8'h03);
    queue_item(MODE_BYTE, FLAG_BYTE);
    queue_item(MODE_BYTE, ESC_BYTE);
    queue_item(MODE_BYTE, 8'hFF);
    queue_item(MODE_BYTE, 8'h00);
    queue_item(MODE_BYTE, 8'hAA);
    queue_item(MODE_BYTE, 8'h55);
    queue_item(MODE_IDLE, 8'h00);
    queue_item(MODE_FETCH, 8'h00);
    queue_item(MODE_FETCH, 8'h00);
    queue_item(MODE_BYTE, 8'h01);
    queue_item(MODE_BYTE, 8'h02);
    queue_item(MODE_BYTE, 8'h03);
    queue_item(MODE_BYTE, 8'h04);
    queue_item(MODE_BYTE, 8'h05);
    queue_item(MODE_IDLE, 8'h00);
    queue_item(MODE_FETCH, 8'h00);
    queue_item(MODE_UNUSED, 8'hFF);
    wait_drained(SETTLE_CYCLES);

    // Master mode: flood the ring with escaped bytes until no delimiter is
    // left, then store a foreign frame and an oversized frame.
    write_reg(CFG_SLAVE_MODE, 8'h00);
    write_reg(CFG_OWN_ADDR, 8'hFF);
    repeat (130) queue_item(MODE_BYTE, $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE);
    queue_item(MODE_FETCH, 8'h00);
    queue_item(MODE_IDLE, 8'h00);
    queue_frame(8'h22, 8);
    queue_frame(8'h33, FRAME_LIMIT + 6);
    wait_drained(SETTLE_CYCLES);

    // Slave mode again: the stored frames now fail the address and size
    // checks, and the last fetch finds nothing beyond the oversized frame.
    write_reg(CFG_SLAVE_MODE, 8'h01);
    repeat (3) queue_item(MODE_FETCH, 8'h00);
    wait_drained(SETTLE_CYCLES);

    // Random traffic under several settings.
    write_reg(CFG_OWN_ADDR, 8'($urandom_range(1, 254)));
    queue_traffic(35);
    wait_drained(SETTLE_CYCLES);

    write_reg(CFG_OWN_ADDR, 8'h00);
    calm = 1'b1;
    queue_traffic(35);
    wait_drained(SETTLE_CYCLES);
    calm = 1'b0;

    write_reg(CFG_SLAVE_MODE, 8'h00);
    write_reg(CFG_OWN_ADDR, 8'($urandom_range(0, 255)));
    queue_traffic(35);
    wait_drained(TAIL_CYCLES);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
